FILE: rtl/frame_allocator_fifo_queue_assert.svh
// ----------------------------------------------------------------------------
// frame allocator assertion macros
// concurrent assertion shorthands used by the checker of this block
// ----------------------------------------------------------------------------
`ifndef FRAME_ALLOCATOR_FIFO_QUEUE_ASSERT_SVH
`define FRAME_ALLOCATOR_FIFO_QUEUE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FAFQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define FAFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fafq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fafq_pkg
// types and codes of the frame allocator with its used-frame queue
// ----------------------------------------------------------------------------
package fafq_pkg;

   localparam int NUM_FRAMES_DEF = 256;
   localparam int FMT_LIMIT      = 256;
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;

   localparam logic [8:0] NUM_FRAMES_RST = 9'd256;

   localparam logic CSR_IDX_NUM_FRAMES = 1'b0;

   localparam logic [2:0] KIND_POP     = 3'd0;
   localparam logic [2:0] KIND_PUSH    = 3'd1;
   localparam logic [2:0] KIND_APPEND  = 3'd2;
   localparam logic [2:0] KIND_DEQUEUE = 3'd3;
   localparam logic [2:0] KIND_REMOVE  = 3'd4;
   localparam logic [2:0] KIND_FORMAT  = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] frame;
      logic [7:0] owner;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_frame;
      logic [7:0] out_owner;
   } rsp_type;

   typedef struct packed {
      logic [7:0] frame;
      logic [7:0] owner;
   } used_entry_type;

endpackage

FILE: rtl/frame_allocator_fifo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_allocator_fifo_queue
// free-frame stack and ordered used-frame queue, one command at a time
// ----------------------------------------------------------------------------
// channel    | ports                                   | transaction
// command    | start, busy, req_data                   | start high, busy low
// result     | rsp_strobe, rsp_data                    | strobe cycle, no stall
// registers  | psel penable pwrite paddr pwdata prdata | psel penable pwrite
//
// push, append, format, unused kinds, empty and full errors answer in idle;
// so does pop of an untouched entry, else pop reads the free-frame memory;
// dequeue reads the used-frame memory; remove walks the queue on its single
// read port. synchronous reset clears control state only; no clearing pass
// is needed. the result is registered at completion and cannot stall.
// ----------------------------------------------------------------------------
module frame_allocator_fifo_queue #(
   parameter int NUM_FRAMES = fafq_pkg::NUM_FRAMES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  fafq_pkg::req_type            req_data,
   output logic                         rsp_strobe,
   output fafq_pkg::rsp_type            rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fafq_pkg::CSR_AW-1:0]  paddr,
   input  logic [fafq_pkg::CSR_DW-1:0]  pwdata,
   output logic [fafq_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);

   localparam int AW      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW      = $clog2(NUM_FRAMES + 1);
   localparam int FMT_MAX = (NUM_FRAMES < fafq_pkg::FMT_LIMIT) ? NUM_FRAMES
                                                               : fafq_pkg::FMT_LIMIT;
   localparam logic [8:0]    FMT_CAP = 9'(FMT_MAX);
   localparam logic [CW-1:0] DEPTH   = CW'(NUM_FRAMES);
   localparam logic [CW:0]   DEPTH_W = (CW+1)'(NUM_FRAMES);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_FREE_RD = 4'b0010,
      ST_USED_RD = 4'b0100,
      ST_SCAN    = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            free_count_ff, free_count_in;
   logic [CW-1:0]            free_low_ff, free_low_in;
   logic [CW-1:0]            fmt_n_ff, fmt_n_in;
   logic [CW-1:0]            used_count_ff, used_count_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            rd_pos_ff, rd_pos_in;
   logic                     found_ff, found_in;
   logic [8:0]               num_frames_ff, num_frames_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   fafq_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   fafq_pkg::req_type        req_ff, req_in;

   logic [7:0]               free_mem [NUM_FRAMES];
   logic                     free_we, free_re;
   logic [AW-1:0]            free_waddr, free_raddr;
   logic [7:0]               free_wdata, free_rd_ff;

   fafq_pkg::used_entry_type used_mem [NUM_FRAMES];
   logic                     used_we, used_re;
   logic [AW-1:0]            used_waddr, used_raddr;
   fafq_pkg::used_entry_type used_wdata, used_rd_ff;

   logic [CW-1:0]            fmt_count;
   logic                     csr_write;
   logic                     match;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(ofs);
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return AW'(sum);
   endfunction

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == fafq_pkg::CSR_IDX_NUM_FRAMES);
   assign prdata    = (paddr[2] == fafq_pkg::CSR_IDX_NUM_FRAMES)
                      ? {{(fafq_pkg::CSR_DW-9){1'b0}}, num_frames_ff}
                      : '0;
   assign num_frames_in = csr_write ? pwdata[8:0] : num_frames_ff;

   assign fmt_count = (num_frames_ff > FMT_CAP) ? CW'(FMT_CAP) : CW'(num_frames_ff);
   assign match     = (used_rd_ff.frame == req_ff.frame);

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      free_count_in = free_count_ff;
      free_low_in   = free_low_ff;
      fmt_n_in      = fmt_n_ff;
      used_count_in = used_count_ff;
      head_in       = head_ff;
      rd_pos_in     = rd_pos_ff;
      found_in      = found_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      free_we       = 1'b0;
      free_re       = 1'b0;
      free_waddr    = '0;
      free_raddr    = '0;
      free_wdata    = '0;
      used_we       = 1'b0;
      used_re       = 1'b0;
      used_waddr    = '0;
      used_raddr    = '0;
      used_wdata    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.kind)
                  fafq_pkg::KIND_POP: begin
                     if (free_count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = fafq_pkg::STATUS_EMPTY;
                     end else if (free_count_ff == free_low_ff) begin
                        // entry untouched since format
                        rsp_strobe_in         = 1'b1;
                        rsp_data_in.status    = fafq_pkg::STATUS_OK;
                        rsp_data_in.out_frame = 8'(fmt_n_ff - free_count_ff);
                        free_count_in         = free_count_ff - 1'b1;
                        free_low_in           = free_count_ff - 1'b1;
                     end else begin
                        free_re       = 1'b1;
                        free_raddr    = AW'(free_count_ff - 1'b1);
                        free_count_in = free_count_ff - 1'b1;
                        state_in      = ST_FREE_RD;
                     end
                  end
                  fafq_pkg::KIND_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (free_count_ff >= DEPTH) begin
                        rsp_data_in.status = fafq_pkg::STATUS_FULL;
                     end else begin
                        free_we            = 1'b1;
                        free_waddr         = AW'(free_count_ff);
                        free_wdata         = req_data.frame;
                        free_count_in      = free_count_ff + 1'b1;
                        rsp_data_in.status = fafq_pkg::STATUS_OK;
                     end
                  end
                  fafq_pkg::KIND_APPEND: begin
                     rsp_strobe_in = 1'b1;
                     if (used_count_ff >= DEPTH) begin
                        rsp_data_in.status = fafq_pkg::STATUS_FULL;
                     end else begin
                        used_we            = 1'b1;
                        used_waddr         = wrap_add(head_ff, used_count_ff);
                        used_wdata.frame   = req_data.frame;
                        used_wdata.owner   = req_data.owner;
                        used_count_in      = used_count_ff + 1'b1;
                        rsp_data_in.status = fafq_pkg::STATUS_OK;
                     end
                  end
                  fafq_pkg::KIND_DEQUEUE: begin
                     if (used_count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = fafq_pkg::STATUS_EMPTY;
                     end else begin
                        used_re       = 1'b1;
                        used_raddr    = head_ff;
                        head_in       = wrap_add(head_ff, CW'(1));
                        used_count_in = used_count_ff - 1'b1;
                        state_in      = ST_USED_RD;
                     end
                  end
                  fafq_pkg::KIND_REMOVE: begin
                     if (used_count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = fafq_pkg::STATUS_EMPTY;
                     end else begin
                        used_re    = 1'b1;
                        used_raddr = head_ff;
                        rd_pos_in  = CW'(1);
                        found_in   = 1'b0;
                        state_in   = ST_SCAN;
                     end
                  end
                  fafq_pkg::KIND_FORMAT: begin
                     rsp_strobe_in      = 1'b1;
                     free_count_in      = fmt_count;
                     free_low_in        = fmt_count;
                     fmt_n_in           = fmt_count;
                     used_count_in      = '0;
                     rsp_data_in.status = (fmt_count == '0) ? fafq_pkg::STATUS_EMPTY
                                                            : fafq_pkg::STATUS_OK;
                  end
                  default: begin
                     rsp_strobe_in      = 1'b1;
                     rsp_data_in.status = fafq_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_FREE_RD: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.status    = fafq_pkg::STATUS_OK;
            rsp_data_in.out_frame = free_rd_ff;
            state_in              = ST_IDLE;
         end
         ST_USED_RD: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.status    = fafq_pkg::STATUS_OK;
            rsp_data_in.out_frame = used_rd_ff.frame;
            rsp_data_in.out_owner = used_rd_ff.owner;
            state_in              = ST_IDLE;
         end
         ST_SCAN: begin
            // entries after the match move one place toward the head
            if (found_ff) begin
               used_we    = 1'b1;
               used_waddr = wrap_add(head_ff, CW'(rd_pos_ff - CW'(2)));
               used_wdata = used_rd_ff;
            end
            found_in = found_ff || match;
            if (rd_pos_ff < used_count_ff) begin
               used_re    = 1'b1;
               used_raddr = wrap_add(head_ff, rd_pos_ff);
               rd_pos_in  = rd_pos_ff + 1'b1;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (found_ff || match) begin
                  rsp_data_in.status = fafq_pkg::STATUS_OK;
                  used_count_in      = used_count_ff - 1'b1;
               end else begin
                  rsp_data_in.status = fafq_pkg::STATUS_NOTFOUND;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_count_ff <= CW'(FMT_CAP);
         free_low_ff   <= CW'(FMT_CAP);
         fmt_n_ff      <= CW'(FMT_CAP);
         used_count_ff <= '0;
         head_ff       <= '0;
         rd_pos_ff     <= '0;
         found_ff      <= 1'b0;
         num_frames_ff <= fafq_pkg::NUM_FRAMES_RST;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         free_low_ff   <= free_low_in;
         fmt_n_ff      <= fmt_n_in;
         used_count_ff <= used_count_in;
         head_ff       <= head_in;
         rd_pos_ff     <= rd_pos_in;
         found_ff      <= found_in;
         num_frames_ff <= num_frames_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   // free-frame stack memory
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      if (free_re) begin
         free_rd_ff <= free_mem[free_raddr];
      end
   end

   // used-frame queue memory, circular from head_ff
   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      if (used_re) begin
         used_rd_ff <= used_mem[used_raddr];
      end
   end

endmodule

FILE: rtl/fafq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fafq_checker
// port-level checks of the frame allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "frame_allocator_fifo_queue_assert.svh"

module fafq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input fafq_pkg::rsp_type            rsp_data,
   input logic                         psel,
   input logic                         pready
);

   logic accepted;
   logic pending;
   logic error_rsp;
   logic payload_zero;

   assign accepted     = start && !busy;
   assign pending      = busy || start;
   assign error_rsp    = rsp_strobe && (rsp_data.status != fafq_pkg::STATUS_OK);
   assign payload_zero = (rsp_data.out_frame == 8'd0) && (rsp_data.out_owner == 8'd0);

   // every transaction either answers next cycle or goes busy
   `FAFQ_ASSERT_NEXT(a_accept_answers, clock, reset, accepted, rsp_strobe || busy, "no answer")

   // a result only follows a command or a busy cycle
   `FAFQ_ASSERT_SAME(a_no_stray_rsp, clock, reset, rsp_strobe, $past(pending), "stray result")

   // error results carry no frame or owner
   `FAFQ_ASSERT_SAME(a_error_zero, clock, reset, error_rsp, payload_zero, "error with payload")

   // register port never waits
   `FAFQ_ASSERT_SAME(a_pready_high, clock, reset, psel, pready, "pready low")

endmodule

bind frame_allocator_fifo_queue fafq_checker u_fafq_checker (.*);
